@@ rtl/rpa_pkg.sv @@
package rpa_pkg;

  // request kinds carried on the input tuser
  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_ADD   = 2'd2,
    ACT_FIND  = 2'd3
  } act_t;

  // result status carried on the output tuser
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOPAGE = 2'd1,
    ST_BADDR  = 2'd2,
    ST_OVF    = 2'd3
  } st_t;

  // shared adder operation
  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_KBASE = 2'd0,
    REG_KEND  = 2'd1,
    REG_TOP   = 2'd2,
    REG_NONE  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [63:0] kernel_base;
    logic [63:0] kernel_end_addr;
    logic [63:0] phys_top;
  } cfg_t;

  typedef struct packed {
    st_t         status;
    logic [63:0] page_addr;
    logic [15:0] ref_count;
    logic        page_released;
  } res_t;

endpackage

@@ rtl/rpa_alu.sv @@
module rpa_alu (
  input  logic [63:0]      a,
  input  logic [63:0]      b,
  input  rpa_pkg::alu_op_t op,
  output logic [63:0]      sum,
  output logic             borrow
);
  import rpa_pkg::*;

  logic [63:0] b_eff;
  logic [64:0] full;

  // one 64-bit adder; subtract is a + ~b + 1
  assign b_eff  = (op == ALU_SUB) ? ~b : b;
  assign full   = {1'b0, a} + {1'b0, b_eff} + 65'((op == ALU_SUB) ? 1 : 0);
  assign sum    = full[63:0];
  assign borrow = (op == ALU_SUB) & ~full[64];

endmodule

@@ rtl/rpa_ctrl.sv @@
module rpa_ctrl #(
  parameter int NUM_PAGES  = 32768,
  parameter int PAGE_SHIFT = 12,
  parameter int COUNT_BITS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  rpa_pkg::cfg_t   cfg,
  input  logic            req_valid,
  input  rpa_pkg::act_t   req_action,
  input  logic [63:0]     req_addr,
  output logic            req_ready,
  input  logic            res_ready,
  output logic            res_valid,
  output rpa_pkg::res_t   res
);
  import rpa_pkg::*;

  localparam int IW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int DW = $clog2(NUM_PAGES + 1);
  localparam int PW = 64 - PAGE_SHIFT;
  localparam logic [DW-1:0] DEPTH_FULL = DW'(NUM_PAGES);
  localparam logic [DW-1:0] CLR_LAST   = DW'(NUM_PAGES - 1);
  localparam logic [PW-1:0] PG_LIMIT   = PW'(NUM_PAGES);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_ARD   = 8'b0000_0100,
    S_CHK0  = 8'b0000_1000,
    S_CHK1  = 8'b0001_0000,
    S_CHK2  = 8'b0010_0000,
    S_RD    = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_t;

  state_t                state_r, state_nxt;
  logic [DW-1:0]         clr_r, clr_nxt;
  logic [DW-1:0]         depth_r, depth_nxt;
  act_t                  action_r;
  logic [63:0]           addr_r;
  logic [IW-1:0]         idx_r;
  logic                  in_range_r;
  logic                  lo_bad_r;
  logic                  hi_ok_r;
  logic [COUNT_BITS-1:0] cnt_rd_r;
  logic [IW-1:0]         stk_rd_r;

  logic [COUNT_BITS-1:0] cnt_mem [NUM_PAGES];
  logic [IW-1:0]         stk_mem [NUM_PAGES];

  logic [63:0]           alu_a, alu_b, alu_sum;
  alu_op_t               alu_op;
  logic                  alu_borrow;

  logic                  fin_go;
  logic                  free_bad;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic                  cnt_we, cnt_upd;
  logic [IW-1:0]         cnt_waddr;
  logic [COUNT_BITS-1:0] cnt_wdata, cnt_new;
  logic                  stk_push, stk_pop;
  logic [DW-1:0]         depth_m1;

  rpa_alu u_alu (
    .a      (alu_a),
    .b      (alu_b),
    .op     (alu_op),
    .sum    (alu_sum),
    .borrow (alu_borrow)
  );

  // operand select for the shared adder
  always_comb begin
    unique case (state_r)
      S_CHK0: begin
        alu_a  = addr_r;
        alu_b  = cfg.kernel_base;
        alu_op = ALU_SUB;
      end
      S_CHK1: begin
        alu_a  = addr_r;
        alu_b  = cfg.kernel_end_addr;
        alu_op = ALU_SUB;
      end
      S_CHK2: begin
        alu_a  = addr_r;
        alu_b  = cfg.phys_top;
        alu_op = ALU_SUB;
      end
      default: begin
        alu_a  = cfg.kernel_base;
        alu_b  = 64'(stk_rd_r) << PAGE_SHIFT;
        alu_op = ALU_ADD;
      end
    endcase
  end

  assign req_ready = (state_r == S_IDLE);
  assign fin_go    = (state_r == S_FIN) && res_ready;
  assign res_valid = fin_go;
  assign depth_m1  = depth_r - DW'(1);
  assign free_bad  = (addr_r[PAGE_SHIFT-1:0] != '0) || lo_bad_r || !hi_ok_r || !in_range_r;
  assign cnt_inc   = (cnt_rd_r == CNT_MAX) ? cnt_rd_r : cnt_rd_r + CNT_ONE;

  // result and memory updates of the final step
  always_comb begin
    res.status        = ST_OK;
    res.page_addr     = '0;
    res.ref_count     = '0;
    res.page_released = 1'b0;
    cnt_upd           = 1'b0;
    cnt_new           = '0;
    cnt_waddr         = idx_r;
    stk_push          = 1'b0;
    stk_pop           = 1'b0;
    unique case (action_r)
      ACT_ALLOC: begin
        if (depth_r == '0) begin
          res.status = ST_NOPAGE;
        end else begin
          stk_pop       = 1'b1;
          cnt_upd       = 1'b1;
          cnt_waddr     = stk_rd_r;
          cnt_new       = CNT_ONE;
          res.page_addr = alu_sum;
          res.ref_count = 16'(CNT_ONE);
        end
      end
      ACT_FREE: begin
        if (free_bad) begin
          res.status = ST_BADDR;
        end else if (cnt_rd_r > CNT_ONE) begin
          cnt_upd       = 1'b1;
          cnt_new       = cnt_rd_r - CNT_ONE;
          res.ref_count = 16'(cnt_new);
        end else begin
          cnt_upd = 1'b1;
          if (depth_r == DEPTH_FULL) begin
            res.status = ST_OVF;
          end else begin
            stk_push          = 1'b1;
            res.page_released = 1'b1;
          end
        end
      end
      ACT_ADD: begin
        if (!in_range_r) begin
          res.status = ST_BADDR;
        end else begin
          cnt_upd       = 1'b1;
          cnt_new       = cnt_inc;
          res.ref_count = 16'(cnt_inc);
        end
      end
      ACT_FIND: begin
        if (!in_range_r) begin
          res.status = ST_BADDR;
        end else begin
          res.ref_count = 16'(cnt_rd_r);
        end
      end
      default: begin
        res.status = ST_OK;
      end
    endcase
  end

  // count memory write port: clearing sweep or final step
  always_comb begin
    if (state_r == S_CLEAR) begin
      cnt_we    = 1'b1;
      cnt_wdata = '0;
    end else begin
      cnt_we    = fin_go && cnt_upd;
      cnt_wdata = cnt_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[(state_r == S_CLEAR) ? clr_r[IW-1:0] : cnt_waddr] <= cnt_wdata;
    end
    if (state_r == S_RD) begin
      cnt_rd_r <= cnt_mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go && stk_push) begin
      stk_mem[depth_r[IW-1:0]] <= idx_r;
    end
    if (state_r == S_ARD) begin
      stk_rd_r <= stk_mem[depth_m1[IW-1:0]];
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    depth_nxt = depth_r;
    unique case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + DW'(1);
        if (clr_r == CLR_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          state_nxt = (req_action == ACT_ALLOC) ? S_ARD : S_CHK0;
        end
      end
      S_ARD:  state_nxt = S_FIN;
      S_CHK0: state_nxt = (action_r == ACT_FREE) ? S_CHK1 : S_RD;
      S_CHK1: state_nxt = S_CHK2;
      S_CHK2: state_nxt = S_RD;
      S_RD:   state_nxt = S_FIN;
      S_FIN: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
          if (stk_push) begin
            depth_nxt = depth_r + DW'(1);
          end else if (stk_pop) begin
            depth_nxt = depth_m1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      depth_r <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      depth_r <= depth_nxt;
    end
  end

  // request capture and address checks
  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      action_r <= req_action;
      addr_r   <= req_addr;
    end
    if (state_r == S_CHK0) begin
      in_range_r <= !alu_borrow && (alu_sum[63:PAGE_SHIFT] < PG_LIMIT);
      idx_r      <= alu_sum[PAGE_SHIFT +: IW];
    end
    if (state_r == S_CHK1) begin
      lo_bad_r <= alu_borrow;
    end
    if (state_r == S_CHK2) begin
      hi_ok_r <= alu_borrow;
    end
  end

endmodule

@@ rtl/refcounted_page_allocator.sv @@
// sequence: allocate runs ARD then FIN; add and find run CHK0, RD, FIN; free runs CHK0, CHK1, CHK2, RD, FIN
// one request at a time; the next beat is taken once the last result is handed to the output register
// reset: synchronous active-low; after reset the count table is cleared one entry per
//   cycle until all NUM_PAGES entries are zero, with in_tready low (config writes still taken)
// free stack starts empty; fill it by freeing every managed page
module refcounted_page_allocator #(
  parameter int NUM_PAGES  = 32768,
  parameter int PAGE_SHIFT = 12,
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [63:0] phys_addr
  input  logic [1:0]  in_tuser,   // [1:0] action
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // [63:0] page_addr, [79:64] ref_count, [80] page_released
  output logic [1:0]  out_tuser,  // [1:0] status
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);
  import rpa_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t reg_sel;
  logic     cfg_wr;

  logic     res_valid;
  logic     res_ready;
  res_t     res;

  logic     out_valid_r;
  res_t     out_r;

  // config registers, 64-bit each at 8-byte spacing
  assign cfg_pready = 1'b1;
  assign reg_sel    = reg_idx_t'(cfg_paddr[4:3]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kernel_base     <= 64'h0000_0000_8000_0000;
      cfg_r.kernel_end_addr <= 64'h0000_0000_8000_0000;
      cfg_r.phys_top        <= 64'h0000_0000_8800_0000;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_KBASE: cfg_r.kernel_base     <= cfg_pwdata;
        REG_KEND:  cfg_r.kernel_end_addr <= cfg_pwdata;
        REG_TOP:   cfg_r.phys_top        <= cfg_pwdata;
        default:   cfg_r.phys_top        <= cfg_r.phys_top;  // unmapped, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_KBASE: cfg_prdata = cfg_r.kernel_base;
      REG_KEND:  cfg_prdata = cfg_r.kernel_end_addr;
      REG_TOP:   cfg_prdata = cfg_r.phys_top;
      default:   cfg_prdata = '0;
    endcase
  end

  // sequencer with count table, free stack and shared adder
  rpa_ctrl #(
    .NUM_PAGES  (NUM_PAGES),
    .PAGE_SHIFT (PAGE_SHIFT),
    .COUNT_BITS (COUNT_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .req_valid  (in_tvalid),
    .req_action (act_t'(in_tuser)),
    .req_addr   (in_tdata),
    .req_ready  (in_tready),
    .res_ready  (res_ready),
    .res_valid  (res_valid),
    .res        (res)
  );

  // output register; the sequencer holds its result while the previous beat still waits
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.status;
  assign out_tdata  = {7'd0, out_r.page_released, out_r.ref_count, out_r.page_addr};

`ifndef SYNTHESIS
  // a failed allocate carries no page and no count
  a_nopage_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_NOPAGE) |-> (out_tdata[79:0] == '0))
    else $error("no-page result with nonzero payload");

  // a released page only comes with an ok status
  a_release_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[80] |-> (out_tuser == ST_OK))
    else $error("page released with error status");

  // a finished result never overwrites a pending beat
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (!out_valid_r || out_tready))
    else $error("result dropped on full output register");

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("ready right after accepting a request");
`endif

endmodule
